// File: sv/tmcd_pkg.sv
// Shared types and constants for the tile mask cross dilation core.
package tmcd_pkg;

  // Command field codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_WORLD_WIDTH  = 3'd0,
    REG_WORLD_HEIGHT = 3'd1,
    REG_BLANK_ID     = 3'd2,
    REG_LAVA_ID      = 3'd3,
    REG_ROCK_ID      = 3'd4,
    REG_BEDROCK_ID   = 3'd5
  } cfg_reg_t;

  // Cross neighbourhood: centre, up, left, right, down
  localparam int NB_COUNT = 5;
  typedef logic [2:0] nb_index_t;
  localparam nb_index_t NB_LAST = 3'd4;

  typedef logic signed [1:0] offset_t;
  localparam offset_t NB_DX [NB_COUNT] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0};
  localparam offset_t NB_DY [NB_COUNT] = '{2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd1};

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      capture;
    logic      mem_wr;
    logic      mem_rd;
    nb_index_t rd_index;
    logic      push;
  } dp_cmd_t;

endpackage

// File: sv/tmcd_ctrl.sv
// Controller state machine: sequences loads, neighbour reads and the result register.
module tmcd_ctrl import tmcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    command,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  state_t    state, state_next;
  nb_index_t rd_count;
  logic      slot_free;

  assign slot_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (command == CMD_LOAD) ? ST_WRITE : ST_READ;
        end
      end
      ST_WRITE:  state_next = ST_IDLE;
      ST_READ: begin
        if (rd_count == NB_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall     = 1'b1;
    cmd          = '0;
    cmd.rd_index = rd_count;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_WRITE:  cmd.mem_wr = 1'b1;
      ST_READ:   cmd.mem_rd = 1'b1;
      ST_FINISH: cmd.push   = slot_free;
      default:   in_stall   = 1'b1;
    endcase
  end

  // State, read step counter and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_count  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        rd_count <= '0;
      end else if (cmd.mem_rd) begin
        rd_count <= rd_count + 3'd1;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/tmcd_datapath.sv
// Datapath: configuration registers, tile classing, mask memory and neighbour OR.
module tmcd_datapath import tmcd_pkg::*; #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 128,
  parameter int BOTTOM_ROWS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [7:0]  tile_x,
  input  logic [6:0]  tile_y,
  input  logic [15:0] fg_item,
  input  logic        tile_present,
  output logic        visible
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [8:0]  world_width;
  logic [7:0]  world_height;
  logic [15:0] blank_id, lava_id, rock_id, bedrock_id;

  logic [7:0]  x_q;
  logic [6:0]  y_q;
  logic        open_q;
  logic        centre_ok_q;

  logic [8:0]  eff_w;
  logic [7:0]  eff_h;
  logic        centre_ok;
  logic        open_bit;
  logic [7:0]  rows_left;

  logic signed [9:0] nx, ny;
  logic              nb_ok;
  logic [AW-1:0]     rd_addr, wr_addr;

  logic mask_mem [DEPTH];
  logic rdata;
  logic rd_valid;
  logic acc;
  logic acc_final;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      world_width  <= 9'd100;
      world_height <= 8'd60;
      blank_id     <= '0;
      lava_id      <= '0;
      rock_id      <= '0;
      bedrock_id   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WORLD_WIDTH:  world_width  <= cfg_data[8:0];
        REG_WORLD_HEIGHT: world_height <= cfg_data[7:0];
        REG_BLANK_ID:     blank_id     <= cfg_data;
        REG_LAVA_ID:      lava_id      <= cfg_data;
        REG_ROCK_ID:      rock_id      <= cfg_data;
        REG_BEDROCK_ID:   bedrock_id   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Clamp map size to the memory geometry
  assign eff_w = (32'(world_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : world_width;
  assign eff_h = (32'(world_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : world_height;

  // Class the incoming tile; bedrock opens only above the bottom rows
  assign centre_ok = (9'(tile_x) < eff_w) && (8'(tile_y) < eff_h);
  assign rows_left = eff_h - 8'(tile_y);
  assign open_bit  = tile_present &&
                     ((fg_item == blank_id) || (fg_item == lava_id) ||
                      (fg_item == rock_id) ||
                      ((fg_item == bedrock_id) && (32'(rows_left) >= BOTTOM_ROWS)));

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_q         <= tile_x;
      y_q         <= tile_y;
      open_q      <= open_bit;
      centre_ok_q <= centre_ok;
    end
  end

  // Neighbour coordinates for the current read step
  always_comb begin
    nx    = $signed({2'b00, x_q}) + 10'(NB_DX[cmd.rd_index]);
    ny    = $signed({3'b000, y_q}) + 10'(NB_DY[cmd.rd_index]);
    nb_ok = centre_ok_q && (nx >= 0) && (ny >= 0) &&
            (nx < $signed({1'b0, eff_w})) && (ny < $signed({2'b00, eff_h}));
  end

  assign rd_addr = AW'(ny[8:0]) * AW'(MAX_WIDTH) + AW'(nx[8:0]);
  assign wr_addr = AW'(y_q) * AW'(MAX_WIDTH) + AW'(x_q);

  // Single-port mask memory
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && centre_ok_q) begin
      mask_mem[wr_addr] <= open_q;
    end else if (cmd.mem_rd && nb_ok) begin
      rdata <= mask_mem[rd_addr];
    end
  end

  // Fold each returned bit into the accumulator
  assign acc_final = acc | (rd_valid & rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      acc      <= 1'b0;
    end else begin
      rd_valid <= cmd.mem_rd && nb_ok;
      acc      <= cmd.capture ? 1'b0 : acc_final;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      visible <= acc_final;
    end
  end

endmodule

// File: sv/tile_mask_cross_dilation_core.sv
// Top level of the tile mask cross dilation core.
// A load, from acceptance: capture, then one mask memory write.
// A query: capture, five neighbour reads on the single mask
// memory port (one per cycle), then a fold into the result register.
// One transaction is in flight at a time; a query holds in its finish state, and
// blocks input, while the previous result is still stalled.
// Reset (rst, synchronous) restores register defaults; mask contents are undefined.
module tile_mask_cross_dilation_core import tmcd_pkg::*; #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 128,
  parameter int BOTTOM_ROWS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  tile_x,
  input  logic [6:0]  tile_y,
  input  logic [15:0] fg_item,
  input  logic        tile_present,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        visible,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  tmcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tmcd_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .BOTTOM_ROWS (BOTTOM_ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tile_x       (tile_x),
    .tile_y       (tile_y),
    .fg_item      (fg_item),
    .tile_present (tile_present),
    .visible      (visible)
  );

  // The memory port never writes and reads in one cycle
  assert property (@(posedge clk) disable iff (rst) !(cmd.mem_wr && cmd.mem_rd))
    else $error("mask memory write and read in the same cycle");

  // Block is busy in the cycle after a transaction is accepted
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is still in flight");

  // A new result appears only after a push from the controller
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(cmd.push))
    else $error("result valid raised without a push");

  // A push never overwrites a result that is still stalled
  assert property (@(posedge clk) disable iff (rst) cmd.push |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the tile mask cross dilation core: loads, queries, register phases.
module tb_top import tmcd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_COLS  = 256;
  localparam int MAP_ROWS  = 128;
  localparam int BASE_ROWS = 6;

  // Register indexes beyond the defined set; writes to them must be ignored
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // Receiver stall behaviours
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // Expected outcome of one accepted query
  typedef struct {
    bit          vis;
    logic [7:0]  x;
    logic [6:0]  y;
  } vis_expect_t;

  // Predicts the dilated visibility bit from its own copy of the open mask
  class cross_mask_predictor;
    int unsigned  cols_reg;
    int unsigned  rows_reg;
    logic [15:0]  blank;
    logic [15:0]  lava;
    logic [15:0]  rock;
    logic [15:0]  bedrock;
    bit           open_bit [MAP_COLS*MAP_ROWS];
    vis_expect_t  pending_vis [$];

    function new();
      cols_reg = 100;
      rows_reg = 60;
      blank    = '0;
      lava     = '0;
      rock     = '0;
      bedrock  = '0;
      foreach (open_bit[i]) open_bit[i] = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      unique case (idx)
        REG_WORLD_WIDTH:  cols_reg = data[8:0];
        REG_WORLD_HEIGHT: rows_reg = data[7:0];
        REG_BLANK_ID:     blank    = data;
        REG_LAVA_ID:      lava     = data;
        REG_ROCK_ID:      rock     = data;
        REG_BEDROCK_ID:   bedrock  = data;
        default: ;
      endcase
    endfunction

    function int unsigned span_x();
      return (cols_reg > MAP_COLS) ? MAP_COLS : cols_reg;
    endfunction

    function int unsigned span_y();
      return (rows_reg > MAP_ROWS) ? MAP_ROWS : rows_reg;
    endfunction

    function bit tile_open(logic [15:0] item, int unsigned y, int unsigned h);
      if (item == blank || item == lava || item == rock) return 1'b1;
      return (item == bedrock) && ((h - y) >= BASE_ROWS);
    endfunction

    // Update the mask on a load, queue the expected bit on a query
    function void note_item(logic cmd, logic [7:0] x, logic [6:0] y,
                            logic [15:0] item, logic pres);
      int unsigned w;
      int unsigned h;
      int          nx;
      int          ny;
      vis_expect_t e;
      w = span_x();
      h = span_y();
      if (cmd == CMD_LOAD) begin
        if (x < w && y < h)
          open_bit[y * MAP_COLS + x] = pres && tile_open(item, y, h);
      end else begin
        e.vis = 1'b0;
        e.x   = x;
        e.y   = y;
        if (x < w && y < h) begin
          for (int k = 0; k < NB_COUNT; k++) begin
            nx = int'(x) + int'(NB_DX[k]);
            ny = int'(y) + int'(NB_DY[k]);
            if (nx >= 0 && ny >= 0 && nx < int'(w) && ny < int'(h))
              e.vis |= open_bit[ny * MAP_COLS + nx];
          end
        end
        pending_vis.push_back(e);
      end
    endfunction

    function bit check_visible(logic v, output string why);
      vis_expect_t e;
      why = "";
      if (pending_vis.size() == 0) begin
        why = $sformatf("visible=%0b arrived with no query outstanding", v);
        return 1'b0;
      end
      e = pending_vis.pop_front();
      if (v !== e.vis) begin
        why = $sformatf("query (%0d,%0d): visible=%0b, expected %0b", e.x, e.y, v, e.vis);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return pending_vis.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = CMD_LOAD;
  logic [7:0]  tile_x = '0;
  logic [6:0]  tile_y = '0;
  logic [15:0] fg_item = '0;
  logic        tile_present = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        visible;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  cross_mask_predictor sb;
  bit       tile_loaded [MAP_COLS*MAP_ROWS];
  int       err_count = 0;
  int       burst_left = 0;
  bit       tx_steady = 1'b0;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;
  int       cyc = 0;
  string    mon_note;

  tile_mask_cross_dilation_core #(
    .MAX_WIDTH   (MAP_COLS),
    .MAX_HEIGHT  (MAP_ROWS),
    .BOTTOM_ROWS (BASE_ROWS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .tile_x       (tile_x),
    .tile_y       (tile_y),
    .fg_item      (fg_item),
    .tile_present (tile_present),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .visible      (visible),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  // Check each result transaction, then pick the next stall value
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (!sb.check_visible(visible, mon_note)) report_mismatch(mon_note);
    end
    cyc <= cyc + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(40, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    unique case (rx_mode)
      RX_FREE:     out_stall <= 1'b0;
      RX_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
      RX_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
      RX_PERIODIC: out_stall <= ((cyc % 5) < 3);
      default:     out_stall <= 1'b0;
    endcase
  end

  // Offer one input transaction, with a random gap at the start of each burst unless tx_steady is set
  task automatic send_item(logic cmd, logic [7:0] x, logic [6:0] y,
                           logic [15:0] item, logic pres);
    int gap;
    if (burst_left == 0) begin
      gap = tx_steady ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    command      <= cmd;
    tile_x       <= x;
    tile_y       <= y;
    fg_item      <= item;
    tile_present <= pres;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(cmd, x, y, item, pres);
  endtask

  task automatic load_tile(logic [7:0] x, logic [6:0] y, logic [15:0] item, logic pres);
    int unsigned w;
    int unsigned h;
    w = sb.span_x();
    h = sb.span_y();
    send_item(CMD_LOAD, x, y, item, pres);
    if (x < w && y < h) tile_loaded[y * MAP_COLS + x] = 1'b1;
  endtask

  // Favour the configured ids so every class rule is hit
  function automatic logic [15:0] pick_item();
    unique case ($urandom_range(0, 4))
      0: return sb.blank;
      1: return sb.lava;
      2: return sb.rock;
      3: return sb.bedrock;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic pick_present();
    return ($urandom_range(0, 9) < 8);
  endfunction

  // Load any in-range neighbour not yet written, then query the tile
  task automatic query_tile(logic [7:0] x, logic [6:0] y);
    int unsigned w;
    int unsigned h;
    int          nx;
    int          ny;
    w = sb.span_x();
    h = sb.span_y();
    if (x < w && y < h) begin
      for (int k = 0; k < NB_COUNT; k++) begin
        nx = int'(x) + int'(NB_DX[k]);
        ny = int'(y) + int'(NB_DY[k]);
        if (nx >= 0 && ny >= 0 && nx < int'(w) && ny < int'(h) &&
            !tile_loaded[ny * MAP_COLS + nx])
          load_tile(8'(nx), 7'(ny), pick_item(), pick_present());
      end
    end
    send_item(CMD_QUERY, x, y, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every result, then let a trailing load finish
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_map(int unsigned w, int unsigned h, logic [15:0] b, logic [15:0] l,
                         logic [15:0] r, logic [15:0] bd);
    write_reg(REG_WORLD_WIDTH, 16'(w));
    write_reg(REG_WORLD_HEIGHT, 16'(h));
    write_reg(REG_BLANK_ID, b);
    write_reg(REG_LAVA_ID, l);
    write_reg(REG_ROCK_ID, r);
    write_reg(REG_BEDROCK_ID, bd);
  endtask

  // Mixed loads and queries, mostly in range, some anywhere in the field range
  task automatic random_ops(int count);
    int unsigned w;
    int unsigned h;
    int unsigned lift;
    logic [7:0]  x;
    logic [6:0]  y;
    tx_steady = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      w = sb.span_x();
      h = sb.span_y();
      if (w == 0 || h == 0 || $urandom_range(0, 99) < 15) begin
        x = 8'($urandom_range(0, 255));
        y = 7'($urandom_range(0, 127));
      end else begin
        x = 8'($urandom_range(0, w - 1));
        if ($urandom_range(0, 2) == 0) begin
          lift = (h - 1 < 7) ? h - 1 : 7;
          y = 7'(h - 1 - $urandom_range(0, lift));
        end else begin
          y = 7'($urandom_range(0, h - 1));
        end
      end
      if ($urandom_range(0, 99) < 55) query_tile(x, y);
      else load_tile(x, y, pick_item(), pick_present());
    end
    settle();
  endtask

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    sb = new();
    foreach (tile_loaded[i]) tile_loaded[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners, absent tiles, bedrock boundary, out-of-range items
    set_map(100, 60, 16'h0000, 16'h0011, 16'h0022, 16'h0007);
    load_tile(0, 0, 16'h0000, 1'b1);
    load_tile(1, 0, 16'hFFFF, 1'b1);
    load_tile(0, 1, 16'h0011, 1'b0);
    query_tile(0, 0);
    load_tile(0, 0, 16'h0022, 1'b0);
    query_tile(0, 0);
    load_tile(50, 54, 16'h0007, 1'b1);
    load_tile(50, 55, 16'h0007, 1'b1);
    load_tile(50, 59, 16'h0007, 1'b1);
    query_tile(50, 55);
    query_tile(50, 59);
    load_tile(99, 59, 16'h0022, 1'b1);
    query_tile(99, 59);
    query_tile(99, 0);
    query_tile(0, 59);
    load_tile(100, 3, 16'h0000, 1'b1);
    load_tile(3, 60, 16'h0000, 1'b1);
    load_tile(255, 127, 16'hFFFF, 1'b1);
    query_tile(255, 127);
    query_tile(100, 0);
    query_tile(0, 60);
    settle();

    // Register phases, extremes first
    set_map(1, 1, rnd16(), rnd16(), rnd16(), rnd16());
    random_ops(20);
    set_map(256, 128, 16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE);
    random_ops(16);
    set_map(511, 255, rnd16(), rnd16(), rnd16(), rnd16());
    write_reg(REG_SPARE_A, rnd16());
    write_reg(REG_SPARE_B, rnd16());
    random_ops(12);
    set_map(2, 7, rnd16(), rnd16(), rnd16(), rnd16());
    random_ops(30);
    set_map(0, 60, rnd16(), rnd16(), rnd16(), rnd16());
    random_ops(15);
    set_map(100, 0, rnd16(), rnd16(), rnd16(), rnd16());
    random_ops(15);
    set_map(5, 5, rnd16(), rnd16(), rnd16(), rnd16());
    random_ops(30);
    set_map(3, 6, 16'h0001, 16'h0001, 16'h0002, 16'h0003);
    random_ops(30);
    repeat (3) begin
      set_map($urandom_range(1, 24), $urandom_range(1, 24), rnd16(), rnd16(), rnd16(), rnd16());
      random_ops(20);
    end
    set_map($urandom_range(1, 256), $urandom_range(1, 128), rnd16(), rnd16(), rnd16(), rnd16());
    random_ops(12);

    // Final drain with a bound, then the verdict
    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      report_mismatch($sformatf("%0d query results never arrived", sb.pending()));
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule
